[hw/rtl/multi_pattern_matcher_top_defines.svh]
// ------------------------------------------------------------------------
// multi_pattern_matcher_top_defines
// Assertion macros shared by the matcher's checker.
// ------------------------------------------------------------------------
`ifndef MULTI_PATTERN_MATCHER_TOP_DEFINES_SVH
`define MULTI_PATTERN_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mpm_pkg.sv]
// ------------------------------------------------------------------------
// mpm_pkg
// Types and constants of the multi-pattern matcher.
// ------------------------------------------------------------------------
package mpm_pkg;

    localparam int unsigned NODES_DEF    = 4096;
    localparam int unsigned ALPHABET_DEF = 26;
    localparam int unsigned CLASSES_DEF  = 8;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_PATTERN = 2'd1,
        OP_BUILD   = 2'd2,
        OP_TEXT    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_AFTER_BUILD = 2'd2
    } status_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] symbol;
        logic       last;
        logic [2:0] cls;
        logic       tstart;
    } item_t;

endpackage

[hw/rtl/mpm_if.sv]
// ------------------------------------------------------------------------
// mpm_if
// Valid/ready channels of the matcher: command items in, results out.
// ------------------------------------------------------------------------
interface mpm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [4:0] symbol;
    logic       pattern_last;
    logic [2:0] pattern_class;
    logic       text_start;

    modport source (output valid, operation, symbol, pattern_last, pattern_class,
                    text_start, input ready);
    modport sink   (input valid, operation, symbol, pattern_last, pattern_class,
                    text_start, output ready);
endinterface

interface mpm_out_if #(
    parameter int unsigned NW = 12,
    parameter int unsigned CW = 8
);
    logic          valid;
    logic          ready;
    logic [CW-1:0] match_mask;
    logic [NW-1:0] node;
    logic [1:0]    status;

    modport source (output valid, match_mask, node, status, input ready);
    modport sink   (input valid, match_mask, node, status, output ready);
endinterface

[hw/rtl/mpm_core.sv]
// ------------------------------------------------------------------------
// mpm_core
// Automaton engine: trie, failure links, masks and BFS queue in
// synchronous memories, walked by one sequencer.
// ------------------------------------------------------------------------
module mpm_core
    import mpm_pkg::*;
#(
    parameter int unsigned NODES    = NODES_DEF,
    parameter int unsigned ALPHABET = ALPHABET_DEF,
    parameter int unsigned CLASSES  = CLASSES_DEF,
    localparam int unsigned NW  = $clog2(NODES),
    localparam int unsigned CW  = CLASSES
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  item_t         item,
    output logic          idle,
    output logic          done,
    output logic [CW-1:0] res_mask,
    output logic [NW-1:0] res_node,
    output status_t       res_status
);

    localparam int unsigned TT_DEPTH = NODES * ALPHABET;
    localparam int unsigned TAW      = $clog2(TT_DEPTH);
    localparam int unsigned CLW      = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int unsigned QW       = NW + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_ZERO, S_FIN,
        S_P_RD, S_P_CHK, S_P_MRD, S_P_MWR,
        S_T_RD, S_T_NX, S_T_MK,
        S_B_V, S_B_W, S_B_ACT, S_B_POP, S_B_FL, S_B_MF, S_B_MR, S_B_MW
    } state_t;

    // memories
    logic [NW-1:0] tt_mem [TT_DEPTH];
    logic [CW-1:0] cm_mem [NODES];
    logic [NW-1:0] fl_mem [NODES];
    logic [NW-1:0] q_mem  [NODES];

    logic [NW-1:0]  tt_node, tt_wdata, tt_rdata;
    logic [CLW-1:0] tt_col;
    logic [TAW-1:0] tt_addr;
    logic           tt_we;
    logic [NW-1:0]  cm_addr, fl_addr, fl_wdata, fl_rdata, q_addr, q_wdata, q_rdata;
    logic [CW-1:0]  cm_wdata, cm_rdata;
    logic           cm_we, fl_we, q_we;

    state_t         state_reg;
    item_t          item_reg;
    logic [QW-1:0]  count_reg, head_reg, tail_reg;
    logic [NW-1:0]  cursor_reg, text_reg, nd_reg, zrow_reg, r_reg, f_reg, v_reg;
    logic [CLW-1:0] col_reg;
    logic [CW-1:0]  mf_reg, mask_reg;
    logic [NW-1:0]  node_reg;
    status_t        status_reg;
    logic           built_reg, report_reg, root_reg;

    logic           col_last, q_room;
    logic [CLW-1:0] sym_col;
    logic [CW-1:0]  cls_bit;
    logic [NW-1:0]  w_eff;

    assign sym_col  = CLW'(item_reg.symbol);
    assign cls_bit  = (32'(item_reg.cls) < CLASSES) ? (CW'(1) << item_reg.cls) : '0;
    assign col_last = col_reg == CLW'(ALPHABET - 1);
    assign q_room   = tail_reg < QW'(NODES);
    assign w_eff    = root_reg ? '0 : tt_rdata;
    assign tt_addr  = TAW'(TAW'(tt_node) * TAW'(ALPHABET)) + TAW'(tt_col);

    // memory port selection
    always_comb
    begin
        tt_node  = cursor_reg;
        tt_col   = sym_col;
        tt_we    = 1'b0;
        tt_wdata = '0;
        cm_addr  = nd_reg;
        cm_we    = 1'b0;
        cm_wdata = '0;
        fl_addr  = q_rdata;
        fl_we    = 1'b0;
        fl_wdata = '0;
        q_addr   = head_reg[NW-1:0];
        q_we     = 1'b0;
        q_wdata  = v_reg;
        unique case (state_reg)
            S_ZERO:
            begin
                tt_node = zrow_reg;
                tt_col  = col_reg;
                tt_we   = 1'b1;
            end
            S_P_CHK:
            begin
                if (tt_rdata == '0 && count_reg < QW'(NODES))
                begin
                    tt_we    = 1'b1;
                    tt_wdata = count_reg[NW-1:0];
                    cm_addr  = count_reg[NW-1:0];
                    cm_we    = 1'b1;
                    cm_wdata = item_reg.last ? cls_bit : '0;
                end
            end
            S_P_MWR:
            begin
                cm_we    = 1'b1;
                cm_wdata = cm_rdata | cls_bit;
            end
            S_T_RD:  tt_node = text_reg;
            S_T_NX:  cm_addr = tt_rdata;
            S_B_V:
            begin
                tt_node = r_reg;
                tt_col  = col_reg;
            end
            S_B_W:
            begin
                tt_node = f_reg;
                tt_col  = col_reg;
            end
            S_B_ACT:
            begin
                tt_node = r_reg;
                tt_col  = col_reg;
                if (v_reg == '0)
                begin
                    tt_we    = 1'b1;
                    tt_wdata = w_eff;
                end
                else if (q_room)
                begin
                    fl_addr  = v_reg;
                    fl_we    = 1'b1;
                    fl_wdata = w_eff;
                    q_addr   = tail_reg[NW-1:0];
                    q_we     = 1'b1;
                end
            end
            S_B_MF:  cm_addr = fl_rdata;
            S_B_MR:  cm_addr = r_reg;
            S_B_MW:
            begin
                cm_addr  = r_reg;
                cm_we    = 1'b1;
                cm_wdata = cm_rdata | mf_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tt_we)
            tt_mem[tt_addr] <= tt_wdata;
        tt_rdata <= tt_mem[tt_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cm_we)
            cm_mem[cm_addr] <= cm_wdata;
        cm_rdata <= cm_mem[cm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (fl_we)
            fl_mem[fl_addr] <= fl_wdata;
        fl_rdata <= fl_mem[fl_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_addr] <= q_wdata;
        q_rdata <= q_mem[q_addr];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_ZERO;
            item_reg   <= '0;
            count_reg  <= QW'(1);
            head_reg   <= '0;
            tail_reg   <= '0;
            cursor_reg <= '0;
            text_reg   <= '0;
            nd_reg     <= '0;
            zrow_reg   <= '0;
            r_reg      <= '0;
            f_reg      <= '0;
            v_reg      <= '0;
            col_reg    <= '0;
            mf_reg     <= '0;
            mask_reg   <= '0;
            node_reg   <= '0;
            status_reg <= ST_OK;
            built_reg  <= 1'b0;
            report_reg <= 1'b0;
            root_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        item_reg   <= item;
                        mask_reg   <= '0;
                        node_reg   <= '0;
                        status_reg <= ST_OK;
                        state_reg  <= S_FIN;
                        unique case (item.op)
                            OP_CLEAR:
                            begin
                                count_reg  <= QW'(1);
                                cursor_reg <= '0;
                                text_reg   <= '0;
                                built_reg  <= 1'b0;
                                zrow_reg   <= '0;
                                col_reg    <= '0;
                                report_reg <= 1'b1;
                                state_reg  <= S_ZERO;
                            end
                            OP_PATTERN:
                            begin
                                if (built_reg)
                                    status_reg <= ST_AFTER_BUILD;
                                else if (32'(item.symbol) >= ALPHABET)
                                    node_reg <= cursor_reg;
                                else
                                    state_reg <= S_P_RD;
                            end
                            OP_BUILD:
                            begin
                                if (!built_reg)
                                begin
                                    r_reg     <= '0;
                                    f_reg     <= '0;
                                    root_reg  <= 1'b1;
                                    col_reg   <= '0;
                                    head_reg  <= '0;
                                    tail_reg  <= '0;
                                    state_reg <= S_B_V;
                                end
                            end
                            OP_TEXT:
                            begin
                                if (32'(item.symbol) >= ALPHABET)
                                    text_reg <= '0;
                                else
                                begin
                                    if (item.tstart)
                                        text_reg <= '0;
                                    state_reg <= S_T_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_ZERO:
                begin
                    col_reg <= col_reg + CLW'(1);
                    if (col_last)
                        state_reg <= report_reg ? S_FIN : S_IDLE;
                end
                S_FIN:   state_reg <= S_IDLE;
                S_P_RD:  state_reg <= S_P_CHK;
                S_P_CHK:
                begin
                    state_reg <= S_FIN;
                    if (tt_rdata != '0)
                    begin
                        node_reg   <= tt_rdata;
                        nd_reg     <= tt_rdata;
                        cursor_reg <= item_reg.last ? '0 : tt_rdata;
                        if (item_reg.last)
                            state_reg <= S_P_MRD;
                    end
                    else if (count_reg >= QW'(NODES))
                    begin
                        status_reg <= ST_FULL;
                        node_reg   <= cursor_reg;
                        if (item_reg.last)
                            cursor_reg <= '0;
                    end
                    else
                    begin
                        node_reg   <= count_reg[NW-1:0];
                        cursor_reg <= item_reg.last ? '0 : count_reg[NW-1:0];
                        count_reg  <= count_reg + QW'(1);
                        zrow_reg   <= count_reg[NW-1:0];
                        col_reg    <= '0;
                        report_reg <= 1'b1;
                        state_reg  <= S_ZERO;
                    end
                end
                S_P_MRD: state_reg <= S_P_MWR;
                S_P_MWR: state_reg <= S_FIN;
                S_T_RD:  state_reg <= S_T_NX;
                S_T_NX:
                begin
                    text_reg  <= tt_rdata;
                    nd_reg    <= tt_rdata;
                    node_reg  <= tt_rdata;
                    state_reg <= S_T_MK;
                end
                S_T_MK:
                begin
                    // root mask is always empty and never stored
                    mask_reg  <= (nd_reg == '0) ? '0 : cm_rdata;
                    state_reg <= S_FIN;
                end
                S_B_V:   state_reg <= S_B_W;
                S_B_W:
                begin
                    v_reg     <= tt_rdata;
                    state_reg <= S_B_ACT;
                end
                S_B_ACT:
                begin
                    if (v_reg != '0 && q_room)
                        tail_reg <= tail_reg + QW'(1);
                    col_reg <= col_reg + CLW'(1);
                    state_reg <= col_last ? S_B_POP : S_B_V;
                end
                S_B_POP:
                begin
                    root_reg <= 1'b0;
                    if (head_reg < tail_reg)
                    begin
                        head_reg  <= head_reg + QW'(1);
                        state_reg <= S_B_FL;
                    end
                    else
                    begin
                        built_reg <= 1'b1;
                        state_reg <= S_FIN;
                    end
                end
                S_B_FL:
                begin
                    r_reg     <= q_rdata;
                    state_reg <= S_B_MF;
                end
                S_B_MF:
                begin
                    f_reg     <= fl_rdata;
                    state_reg <= S_B_MR;
                end
                S_B_MR:
                begin
                    mf_reg    <= (f_reg == '0) ? '0 : cm_rdata;
                    state_reg <= S_B_MW;
                end
                S_B_MW:
                begin
                    col_reg   <= '0;
                    state_reg <= S_B_V;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign idle       = state_reg == S_IDLE;
    assign done       = state_reg == S_FIN;
    assign res_mask   = mask_reg;
    assign res_node   = node_reg;
    assign res_status = status_reg;

endmodule

[hw/rtl/multi_pattern_matcher_top.sv]
// ------------------------------------------------------------------------
// multi_pattern_matcher_top
// Aho-Corasick matcher with valid/ready command and result channels.
// ------------------------------------------------------------------------
// Usage:
//   cmd carries one item per handshake: clear, pattern symbol, build, or
//   text symbol. Every item returns exactly one result item on res
//   (match_mask, node, status), in order.
//   Items are handled one at a time; cmd.ready rises once the engine is
//   idle and the result register is empty or being drained.
//   What each item involves:
//     text symbol            two dependent memory reads: trie, mask
//     pattern, existing node a trie read, plus a mask update when it ends a pattern
//     pattern, new node      the new trie row is zeroed
//     clear                  root row is zeroed
//     build                  a pass over the root row, then over each non-root node in BFS order
//     others                 no memory work
//   The trie memory has a single port, so these steps run one after another.
//   After reset the root row is zeroed; cmd.ready stays low during that sweep.
//   A stalled res holds its item; no new item is taken until it drains.
// ------------------------------------------------------------------------
module multi_pattern_matcher_top
    import mpm_pkg::*;
#(
    parameter int unsigned NODES    = NODES_DEF,
    parameter int unsigned ALPHABET = ALPHABET_DEF,
    parameter int unsigned CLASSES  = CLASSES_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    mpm_in_if.sink     cmd,
    mpm_out_if.source  res
);

    localparam int unsigned NW = $clog2(NODES);
    localparam int unsigned CW = CLASSES;

    item_t         item;
    logic          core_idle, core_done;
    logic [CW-1:0] core_mask;
    logic [NW-1:0] core_node;
    status_t       core_status;

    // result register
    logic          out_valid_reg;
    logic [CW-1:0] out_mask_reg;
    logic [NW-1:0] out_node_reg;
    status_t       out_status_reg;

    assign item.op     = op_t'(cmd.operation);
    assign item.symbol = cmd.symbol;
    assign item.last   = cmd.pattern_last;
    assign item.cls    = cmd.pattern_class;
    assign item.tstart = cmd.text_start;

    // one item in flight; result slot must be free by the time it finishes
    assign cmd.ready = core_idle && (!out_valid_reg || res.ready);

    mpm_core #(
        .NODES    (NODES),
        .ALPHABET (ALPHABET),
        .CLASSES  (CLASSES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.valid && cmd.ready),
        .item       (item),
        .idle       (core_idle),
        .done       (core_done),
        .res_mask   (core_mask),
        .res_node   (core_node),
        .res_status (core_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (core_done)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (core_done)
        begin
            out_mask_reg   <= core_mask;
            out_node_reg   <= core_node;
            out_status_reg <= core_status;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.match_mask = out_mask_reg;
    assign res.node       = out_node_reg;
    assign res.status     = out_status_reg;

endmodule

[hw/rtl/mpm_checker.sv]
// ------------------------------------------------------------------------
// mpm_checker
// Port-level checks of the matcher, bound to the top level.
// ------------------------------------------------------------------------
`include "multi_pattern_matcher_top_defines.svh"

module mpm_checker
    import mpm_pkg::*;
#(
    parameter int unsigned NW = 12,
    parameter int unsigned CW = 8
)(
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_ready,
    input logic          res_valid,
    input logic          res_ready,
    input logic [CW-1:0] res_mask,
    input logic [NW-1:0] res_node,
    input logic [1:0]    res_status
);

    `MPM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_node), "result dropped while stalled")
    `MPM_ASSERT_NEXT(a_one_item, cmd_valid && cmd_ready, !cmd_ready, "second item taken while busy")
    `MPM_ASSERT_NOW(a_mask_text, res_valid && res_status != ST_OK, res_mask == '0, "mask on a non-text result")
    `MPM_ASSERT_NOW(a_ignored_node, res_valid && res_status == ST_AFTER_BUILD, res_node == '0, "ignored pattern reports a node")

endmodule

bind multi_pattern_matcher_top mpm_checker #(
    .NW (NW),
    .CW (CW)
) u_mpm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_mask   (res.match_mask),
    .res_node   (res.node),
    .res_status (res.status)
);

[tb/tb_multi_pattern_matcher_top.sv]
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// tb_multi_pattern_matcher_top
// Self-checking bench for the Aho-Corasick matcher. A clocked driver feeds
// command items from a queue and predicts each result at acceptance; a
// clocked monitor compares every result item, in order, field by field.
// ------------------------------------------------------------------------
module tb_multi_pattern_matcher_top;
    import mpm_pkg::*;

    localparam int unsigned NODES    = NODES_DEF;
    localparam int unsigned ALPHABET = ALPHABET_DEF;
    localparam int unsigned CLASSES  = CLASSES_DEF;

    typedef struct packed {
        logic [7:0]  mask;
        logic [11:0] node;
        status_t     status;
    } match_res_t;

    logic clk;
    logic rst_n;

    mpm_in_if                       cmd_if();
    mpm_out_if #(.NW(12), .CW(8))   res_if();

    multi_pattern_matcher_top #(
        .NODES    (NODES),
        .ALPHABET (ALPHABET),
        .CLASSES  (CLASSES)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    // Stimulus and expectation stores.
    item_t      cmd_pending[$];
    match_res_t match_expected[$];

    // Idle rates in percent, changed per phase by the stimulus process.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Long receiver hold-off: a one-cycle request loads the counter.
    logic        hold_req = 1'b0;
    int unsigned hold_left;

    int unsigned errors     = 0;
    int unsigned mismatches = 0;
    int unsigned n_results  = 0;
    int unsigned n_matches  = 0;
    int unsigned n_full     = 0;
    int unsigned n_builds   = 0;

    // ---------------- predictor state ----------------
    logic [11:0] trie_next [NODES*ALPHABET];
    logic [7:0]  node_mask [NODES];
    logic [11:0] fail_to   [NODES];
    logic [11:0] bfs_order [NODES];
    int unsigned n_nodes;
    logic [11:0] cursor;
    logic [11:0] text_at;
    logic        linked;

    function automatic int unsigned idx(int unsigned nd, int unsigned c);
        return nd * ALPHABET + c;
    endfunction

    function automatic void zero_row(int unsigned nd);
        for (int unsigned c = 0; c < ALPHABET; c++)
            trie_next[idx(nd, c)] = '0;
    endfunction

    function automatic void empty_trie();
        zero_row(0);
        node_mask[0] = '0;
        n_nodes = 1;
        cursor  = '0;
        text_at = '0;
        linked  = 1'b0;
    endfunction

    // Breadth-first pass: failure links, missing transitions, merged masks.
    function automatic void link_trie();
        int unsigned head;
        int unsigned tail;
        logic [11:0] r;
        logic [11:0] f;
        logic [11:0] v;
        head = 0;
        tail = 0;
        fail_to[0] = '0;
        for (int unsigned c = 0; c < ALPHABET; c++) begin
            v = trie_next[idx(0, c)];
            if (v != 0 && tail < NODES) begin
                bfs_order[tail] = v;
                tail++;
                fail_to[v] = '0;
            end
        end
        while (head < tail) begin
            r = bfs_order[head];
            head++;
            f = fail_to[r];
            node_mask[r] |= node_mask[f];
            for (int unsigned c = 0; c < ALPHABET; c++) begin
                v = trie_next[idx(r, c)];
                if (v == 0) begin
                    trie_next[idx(r, c)] = trie_next[idx(f, c)];
                end
                else if (tail < NODES) begin
                    fail_to[v] = trie_next[idx(f, c)];
                    bfs_order[tail] = v;
                    tail++;
                end
            end
        end
        linked = 1'b1;
    endfunction

    function automatic match_res_t predict_match(item_t it);
        match_res_t  r;
        logic [11:0] child;
        r = '{mask: '0, node: '0, status: ST_OK};
        case (it.op)
            OP_CLEAR: empty_trie();
            OP_PATTERN:
            begin
                if (linked) begin
                    r.status = ST_AFTER_BUILD;
                end
                else if (it.symbol >= ALPHABET) begin
                    r.node = cursor;
                end
                else begin
                    child = trie_next[idx(cursor, it.symbol)];
                    if (child == 0) begin
                        if (n_nodes >= NODES) begin
                            r.status = ST_FULL;
                            r.node   = cursor;
                            if (it.last)
                                cursor = '0;
                        end
                        else begin
                            child = n_nodes[11:0];
                            n_nodes++;
                            zero_row(child);
                            node_mask[child] = '0;
                            trie_next[idx(cursor, it.symbol)] = child;
                        end
                    end
                    if (r.status == ST_OK) begin
                        cursor = child;
                        r.node = child;
                        if (it.last) begin
                            if (it.cls < CLASSES)
                                node_mask[child] |= 8'(1) << it.cls;
                            cursor = '0;
                        end
                    end
                end
            end
            OP_BUILD:
            begin
                if (!linked)
                    link_trie();
            end
            default:
            begin
                if (it.tstart || it.symbol >= ALPHABET)
                    text_at = '0;
                if (it.symbol < ALPHABET) begin
                    text_at = trie_next[idx(text_at, it.symbol)];
                    r.mask  = node_mask[text_at];
                end
                r.node = text_at;
            end
        endcase
        return r;
    endfunction

    // ---------------- clock, reset, limit ----------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #20ms;
        $display("timeout: %0d results still expected", match_expected.size());
        $display("status: fail");
        $finish;
    end

    // ---------------- driver ----------------
    // Predicts at acceptance, then offers the next item unless idling.
    // A held item is never dropped or re-driven in the same step.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cmd_if.valid         <= 1'b0;
            cmd_if.operation     <= OP_CLEAR;
            cmd_if.symbol        <= '0;
            cmd_if.pattern_last  <= 1'b0;
            cmd_if.pattern_class <= '0;
            cmd_if.text_start    <= 1'b0;
        end
        else begin
            if (cmd_if.valid && cmd_if.ready) begin
                item_t acc;
                acc = '{op: op_t'(cmd_if.operation), symbol: cmd_if.symbol,
                        last: cmd_if.pattern_last, cls: cmd_if.pattern_class,
                        tstart: cmd_if.text_start};
                if (acc.op == OP_BUILD && !linked)
                    n_builds++;
                match_expected.push_back(predict_match(acc));
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (cmd_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item_t nx;
                    nx = cmd_pending.pop_front();
                    cmd_if.valid         <= 1'b1;
                    cmd_if.operation     <= nx.op;
                    cmd_if.symbol        <= nx.symbol;
                    cmd_if.pattern_last  <= nx.last;
                    cmd_if.pattern_class <= nx.cls;
                    cmd_if.text_start    <= nx.tstart;
                end
                else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= 400;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready) begin
            match_res_t want;
            n_results++;
            if (match_expected.size() == 0) begin
                errors++;
                $display("unexpected result: mask %h node %0d status %0d",
                         res_if.match_mask, res_if.node, res_if.status);
            end
            else begin
                want = match_expected.pop_front();
                if (res_if.match_mask != want.mask || res_if.node != want.node ||
                    res_if.status != want.status) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch #%0d: want mask %h node %0d status %0d,",
                                  " got mask %h node %0d status %0d"},
                                 n_results, want.mask, want.node, want.status,
                                 res_if.match_mask, res_if.node, res_if.status);
                end
                if (want.mask != 0)
                    n_matches++;
                if (want.status == ST_FULL)
                    n_full++;
            end
        end
    end

    // ---------------- stimulus ----------------
    int unsigned n_pushed = 0;

    task automatic add_item(op_t op, int unsigned sym, bit last, int unsigned cls, bit ts);
        cmd_pending.push_back('{op: op, symbol: 5'(sym), last: last, cls: 3'(cls),
                                tstart: ts});
        n_pushed++;
    endtask

    task automatic add_noise();
        add_item(op_t'($urandom_range(3)), $urandom_range(31), $urandom_range(1),
                 $urandom_range(7), $urandom_range(1));
    endtask

    // One session: clear, patterns, usually a build, then text drawn mostly from the
    // same letters so that matches actually happen; random noise items are mixed in.
    task automatic add_session();
        int unsigned top_sym;
        int unsigned n_pat;
        int unsigned len;
        top_sym = ($urandom_range(3) == 0) ? ALPHABET - 1 : $urandom_range(1, 3);
        add_item(OP_CLEAR, $urandom_range(31), $urandom_range(1), $urandom_range(7), 1'b0);
        n_pat = $urandom_range(1, 6);
        for (int p = 0; p < n_pat; p++) begin
            len = $urandom_range(1, 5);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(19) == 0)
                    add_noise();
                add_item(OP_PATTERN, $urandom_range(top_sym), k == len - 1,
                         $urandom_range(7), $urandom_range(1));
            end
        end
        if ($urandom_range(9) != 0)
            add_item(OP_BUILD, $urandom_range(31), 1'b0, 0, 1'b0);
        if ($urandom_range(4) == 0)
            add_item(OP_PATTERN, $urandom_range(31), $urandom_range(1), $urandom_range(7), 1'b0);
        if ($urandom_range(4) == 0)
            add_item(OP_BUILD, 0, 1'b0, 0, 1'b0);
        len = $urandom_range(20, 60);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(24) == 0)
                add_noise();
            else
                add_item(OP_TEXT, ($urandom_range(29) == 0) ? $urandom_range(26, 31)
                         : $urandom_range(top_sym), $urandom_range(1), $urandom_range(7),
                         $urandom_range(19) == 0);
        end
    endtask

    task automatic drain_all();
        while (cmd_pending.size() != 0 || cmd_if.valid || match_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int unsigned goal);
        while (n_pushed < goal)
            add_session();
    endtask

    initial
    begin
        empty_trie();
        for (int unsigned i = 0; i < NODES*ALPHABET; i++)
            trie_next[i] = '0;
        for (int unsigned i = 0; i < NODES; i++)
            node_mask[i] = '0;

        // Directed: empty-trie text, field extremes, out-of-range symbols,
        // text before build, repeated build, pattern after build, clear.
        add_item(OP_TEXT, 0, 1'b0, 0, 1'b0);
        add_item(OP_PATTERN, 0, 1'b1, 0, 1'b0);
        add_item(OP_PATTERN, 25, 1'b0, 7, 1'b1);
        add_item(OP_PATTERN, 31, 1'b1, 7, 1'b0);
        add_item(OP_PATTERN, 0, 1'b1, 7, 1'b0);
        add_item(OP_PATTERN, 25, 1'b1, 3, 1'b0);
        add_item(OP_TEXT, 25, 1'b0, 0, 1'b0);
        add_item(OP_TEXT, 0, 1'b1, 7, 1'b0);
        add_item(OP_TEXT, 26, 1'b0, 0, 1'b0);
        add_item(OP_TEXT, 25, 1'b0, 0, 1'b1);
        add_item(OP_BUILD, 31, 1'b1, 7, 1'b1);
        add_item(OP_BUILD, 0, 1'b0, 0, 1'b0);
        add_item(OP_PATTERN, 1, 1'b1, 1, 1'b0);
        add_item(OP_TEXT, 0, 1'b0, 0, 1'b0);
        add_item(OP_TEXT, 25, 1'b0, 0, 1'b0);
        add_item(OP_TEXT, 25, 1'b0, 0, 1'b0);
        add_item(OP_TEXT, 31, 1'b1, 7, 1'b1);
        add_item(OP_CLEAR, 31, 1'b1, 7, 1'b1);
        add_item(OP_TEXT, 0, 1'b0, 0, 1'b0);
        add_item(OP_PATTERN, 2, 1'b1, 5, 1'b0);

        // Phase A: sender rarely idles, receiver stalls often.
        send_idle_pct = 6;
        recv_idle_pct = 66;
        run_phase(650);
        repeat (30) @(negedge clk);
        hold_req = 1'b1;            // long stall while items keep coming
        @(negedge clk);
        hold_req = 1'b0;
        drain_all();                // sender pauses until all results are in

        // Phase B: the other way round.
        send_idle_pct = 66;
        recv_idle_pct = 6;
        run_phase(1250);
        drain_all();

        // Phase C: no idling.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(1850);
        drain_all();
        repeat (200) @(posedge clk);

        $display("covered %0d items, %0d results, %0d builds, %0d with a match, %0d store-full",
                 n_pushed, n_results, n_builds, n_matches, n_full);
        $display("mismatches %0d, other errors %0d, left over %0d",
                 mismatches, errors - mismatches, match_expected.size());
        if (errors == 0 && match_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
